[src/double_ended_queue_top_assert.svh]
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dq_pkg.sv]
package dq_pkg;

  // Command codes
  localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [3:0] CMD_PUSH_BACK  = 4'd1;
  localparam logic [3:0] CMD_POP_FRONT  = 4'd2;
  localparam logic [3:0] CMD_POP_BACK   = 4'd3;
  localparam logic [3:0] CMD_CLEAR      = 4'd4;
  localparam logic [3:0] CMD_PEEK_FRONT = 4'd5;
  localparam logic [3:0] CMD_PEEK_BACK  = 4'd6;
  localparam logic [3:0] CMD_EMPTY      = 4'd7;
  localparam logic [3:0] CMD_SIZE       = 4'd8;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FAIL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CMP  = 2'b10
  } state_t;

endpackage

[src/double_ended_queue_top.sv]
// Bounded deque over a ring store, one result per command on a one-cycle strobe.
// Push, pop, clear, empty, size and a peek on an empty queue give their result in the
// cycle after the transfer; other peeks pass S_CMP to await the store's registered read.
// Throughput: 1 command per cycle, but a peek on a non-empty queue holds busy in S_CMP.
// Reset (synchronous, active low) empties the queue; store contents stay undefined.
module double_ended_queue_top #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [3:0]                       in_command,
  input  logic signed [31:0]               in_value,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [$clog2(DEPTH+1)-1:0]       out_count
);

  `include "double_ended_queue_top_assert.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // ring index width
  localparam int CW = $clog2(DEPTH + 1);                // count width, holds DEPTH

  dq_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] cmp_word_r, cmp_word_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;

  // store port
  logic                  we;
  logic [AW-1:0]         waddr;
  logic                  re;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic                  accept;
  logic                  is_empty;
  logic                  is_full;
  logic                  is_peek;
  logic [DATA_WIDTH-1:0] word;
  logic [95:0]           value_ext;

  // Ring position base+off, with base < DEPTH and off <= DEPTH.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // value is sign extended, then cut to the word width
  assign value_ext = {{64{in_value[31]}}, in_value};
  assign word      = value_ext[DATA_WIDTH-1:0];

  assign busy     = (state_r == dq_pkg::S_CMP);
  assign accept   = start && !busy;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_peek  = (in_command == dq_pkg::CMD_PEEK_FRONT) ||
                    (in_command == dq_pkg::CMD_PEEK_BACK);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    cmp_word_nxt   = cmp_word_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    we             = 1'b0;
    waddr          = front_r;
    re             = 1'b0;
    raddr          = front_r;

    unique case (state_r)
      dq_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_nxt  = !is_peek;
          out_status_nxt = dq_pkg::STAT_OK;
          unique case (in_command)
            dq_pkg::CMD_PUSH_FRONT: begin
              if (is_full) begin
                out_status_nxt = dq_pkg::STAT_FULL;
              end else begin
                front_nxt = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
                we        = 1'b1;
                waddr     = front_nxt;
                count_nxt = count_r + CW'(1);
              end
            end
            dq_pkg::CMD_PUSH_BACK: begin
              if (is_full) begin
                out_status_nxt = dq_pkg::STAT_FULL;
              end else begin
                we        = 1'b1;
                waddr     = ring_add(front_r, count_r);
                count_nxt = count_r + CW'(1);
              end
            end
            dq_pkg::CMD_POP_FRONT: begin
              if (is_empty) begin
                out_status_nxt = dq_pkg::STAT_EMPTY;
              end else begin
                front_nxt = ring_add(front_r, CW'(1));
                count_nxt = count_r - CW'(1);
              end
            end
            dq_pkg::CMD_POP_BACK: begin
              if (is_empty) begin
                out_status_nxt = dq_pkg::STAT_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            dq_pkg::CMD_CLEAR: begin
              front_nxt = '0;
              count_nxt = '0;
            end
            dq_pkg::CMD_PEEK_FRONT, dq_pkg::CMD_PEEK_BACK: begin
              if (is_empty) begin
                // nothing to read: report right away
                out_valid_nxt  = 1'b1;
                out_status_nxt = dq_pkg::STAT_EMPTY;
              end else begin
                re           = 1'b1;
                raddr        = (in_command == dq_pkg::CMD_PEEK_FRONT) ? front_r :
                               ring_add(front_r, count_r - CW'(1));
                cmp_word_nxt = word;
                state_nxt    = dq_pkg::S_CMP;
              end
            end
            dq_pkg::CMD_EMPTY: begin
              out_status_nxt = is_empty ? dq_pkg::STAT_OK : dq_pkg::STAT_FAIL;
            end
            dq_pkg::CMD_SIZE: begin
              out_status_nxt = dq_pkg::STAT_OK;
            end
            default: begin
              out_status_nxt = dq_pkg::STAT_FAIL;  // unknown command
            end
          endcase
          out_count_nxt = count_nxt;
        end
      end
      dq_pkg::S_CMP: begin
        // read data of the peeked slot is valid now
        out_valid_nxt  = 1'b1;
        out_status_nxt = (rdata == cmp_word_r) ? dq_pkg::STAT_OK : dq_pkg::STAT_FAIL;
        out_count_nxt  = count_r;
        state_nxt      = dq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = dq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dq_pkg::S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_word_r   <= cmp_word_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  dq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (word),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  `DQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "count above depth")
  `DQ_ASSERT_NEXT(a_peek_waits, clk, rst_n, accept && is_peek && !is_empty, busy && !out_valid, "peek did not wait for read")
  `DQ_ASSERT_NEXT(a_cmp_result, clk, rst_n, busy, out_valid && !busy, "compare gave no result")
  `DQ_ASSERT_NEXT(a_one_result, clk, rst_n, accept && !(is_peek && !is_empty), out_valid && !busy, "command gave no result")
  `DQ_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && (out_status == dq_pkg::STAT_FULL), out_count == CW'(DEPTH), "full reported below depth")

endmodule

[src/dq_ram.sv]
// Simple dual-port ring store, registered read.
module dq_ram #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 10
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH      = 1024;
  localparam int CYCLE_CAP  = 200000;  // far above the slowest legal run
  localparam int DRAIN_WAIT = 4;       // peeks answer after the store read and S_CMP

  // Status and count of one result, as the block reports them.
  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] count;
  } deq_result_t;

  // Scoreboard: keeps its own copy of the deque, predicts each result
  // when a command transfers, and matches results in order.
  class deque_scoreboard;
    localparam int SLOTS = 1024;

    logic [31:0] ring[SLOTS];
    logic [9:0]  head;
    logic [10:0] fill;
    deq_result_t awaited[$];
    int          errors;

    function new();
      head   = '0;
      fill   = '0;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int held();
      return int'(fill);
    endfunction

    function logic [31:0] front_word();
      return ring[head];
    endfunction

    function logic [31:0] back_word();
      logic [9:0] slot;
      slot = head + 10'(fill - 11'd1);
      return ring[slot];
    endfunction

    // Update the mirrored deque for one transferred command.
    function void apply_command(logic [3:0] cmd, logic [31:0] val);
      deq_result_t res;
      logic [9:0]  slot;
      res.status = dq_pkg::STAT_OK;
      case (cmd)
        dq_pkg::CMD_PUSH_FRONT: begin
          if (fill == 11'(SLOTS)) begin
            res.status = dq_pkg::STAT_FULL;
          end else begin
            head       = head - 10'd1;
            ring[head] = val;
            fill       = fill + 11'd1;
          end
        end
        dq_pkg::CMD_PUSH_BACK: begin
          if (fill == 11'(SLOTS)) begin
            res.status = dq_pkg::STAT_FULL;
          end else begin
            slot       = head + 10'(fill);
            ring[slot] = val;
            fill       = fill + 11'd1;
          end
        end
        dq_pkg::CMD_POP_FRONT: begin
          if (fill == 0) begin
            res.status = dq_pkg::STAT_EMPTY;
          end else begin
            head = head + 10'd1;
            fill = fill - 11'd1;
          end
        end
        dq_pkg::CMD_POP_BACK: begin
          if (fill == 0) res.status = dq_pkg::STAT_EMPTY;
          else fill = fill - 11'd1;
        end
        dq_pkg::CMD_CLEAR: begin
          fill = '0;
          head = '0;
        end
        dq_pkg::CMD_PEEK_FRONT: begin
          if (fill == 0) res.status = dq_pkg::STAT_EMPTY;
          else res.status = (ring[head] == val) ? dq_pkg::STAT_OK : dq_pkg::STAT_FAIL;
        end
        dq_pkg::CMD_PEEK_BACK: begin
          if (fill == 0) res.status = dq_pkg::STAT_EMPTY;
          else res.status = (back_word() == val) ? dq_pkg::STAT_OK : dq_pkg::STAT_FAIL;
        end
        dq_pkg::CMD_EMPTY: res.status = (fill == 0) ? dq_pkg::STAT_OK : dq_pkg::STAT_FAIL;
        dq_pkg::CMD_SIZE:  res.status = dq_pkg::STAT_OK;
        default:           res.status = dq_pkg::STAT_FAIL;
      endcase
      res.count = fill;
      awaited.push_back(res);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [1:0] status, logic [10:0] count);
      deq_result_t exp_res;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing pending: status %0d count %0d", status, count));
      end else begin
        exp_res = awaited.pop_front();
        if (status !== exp_res.status)
          report($sformatf("status %0d, predicted %0d", status, exp_res.status));
        if (count !== exp_res.count)
          report($sformatf("count %0d, predicted %0d", count, exp_res.count));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_command;
  logic [31:0] in_value;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [10:0] out_count;

  deque_scoreboard sb;
  bit idle_enable;
  int cycle_count = 0;

  double_ended_queue_top #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (32)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_count  (out_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result monitor: the strobe lasts one cycle and cannot be held off,
  // so every strobe seen at a rising edge is a transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_count);
  end

  // One command transfer. Inputs move on the falling edge; random idle
  // cycles drop start before the command is offered. Returns at the
  // rising edge where start met a low busy.
  task automatic send_cmd(input logic [3:0] cmd, input logic [31:0] val);
    @(negedge clk);
    while (idle_enable && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.apply_command(cmd, val);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Push values lean on the extremes; the rest is fully random.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Peek operand: half the time the word actually held at that end,
  // sometimes that word with one bit flipped, otherwise anything.
  function automatic logic [31:0] peek_value(input logic [3:0] cmd);
    logic [31:0] held_word;
    if (sb.held() == 0) return pick_value();
    held_word = (cmd == dq_pkg::CMD_PEEK_FRONT) ? sb.front_word() : sb.back_word();
    case ($urandom_range(3))
      0, 1:    return held_word;
      2:       return held_word ^ (32'd1 << $urandom_range(31));
      default: return pick_value();
    endcase
  endfunction

  function automatic logic [3:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 17) return dq_pkg::CMD_PUSH_FRONT;
    if (r < 34) return dq_pkg::CMD_PUSH_BACK;
    if (r < 46) return dq_pkg::CMD_POP_FRONT;
    if (r < 58) return dq_pkg::CMD_POP_BACK;
    if (r < 60) return dq_pkg::CMD_CLEAR;
    if (r < 70) return dq_pkg::CMD_PEEK_FRONT;
    if (r < 80) return dq_pkg::CMD_PEEK_BACK;
    if (r < 86) return dq_pkg::CMD_EMPTY;
    if (r < 92) return dq_pkg::CMD_SIZE;
    return 4'($urandom_range(15, 9));   // undefined codes
  endfunction

  task automatic send_random(input logic [3:0] cmd);
    if (cmd == dq_pkg::CMD_PEEK_FRONT || cmd == dq_pkg::CMD_PEEK_BACK)
      send_cmd(cmd, peek_value(cmd));
    else send_cmd(cmd, pick_value());
  endtask

  task automatic random_mix(input int n);
    repeat (n) send_random(pick_command());
  endtask

  initial begin
    sb          = new();
    idle_enable = 1'b1;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_command  = dq_pkg::CMD_SIZE;
    in_value    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every command on an empty deque, then on a short one.
    send_cmd(dq_pkg::CMD_POP_FRONT,  32'h0);
    send_cmd(dq_pkg::CMD_POP_BACK,   32'h0);
    send_cmd(dq_pkg::CMD_PEEK_FRONT, 32'h0);
    send_cmd(dq_pkg::CMD_PEEK_BACK,  32'hFFFF_FFFF);
    send_cmd(dq_pkg::CMD_EMPTY,      32'h0);
    send_cmd(dq_pkg::CMD_SIZE,       32'h0);
    send_cmd(dq_pkg::CMD_CLEAR,      32'h0);
    send_cmd(dq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);  // front index wraps below zero
    send_cmd(dq_pkg::CMD_PUSH_BACK,  32'h8000_0000);
    send_cmd(dq_pkg::CMD_PEEK_FRONT, 32'h7FFF_FFFF);
    send_cmd(dq_pkg::CMD_PEEK_BACK,  32'h8000_0000);
    send_cmd(dq_pkg::CMD_PEEK_FRONT, 32'h0);          // compare mismatch
    send_cmd(dq_pkg::CMD_PEEK_BACK,  32'hFFFF_FFFF);
    send_cmd(dq_pkg::CMD_EMPTY,      32'h0);          // not empty -> fail
    send_cmd(dq_pkg::CMD_SIZE,       32'hFFFF_FFFF);
    send_cmd(4'd9,                   32'h0);          // undefined codes
    send_cmd(4'd15,                  32'hFFFF_FFFF);
    send_cmd(dq_pkg::CMD_PUSH_FRONT, 32'h0);
    send_cmd(dq_pkg::CMD_PUSH_BACK,  32'hFFFF_FFFF);
    send_cmd(dq_pkg::CMD_POP_BACK,   32'h0);
    send_cmd(dq_pkg::CMD_POP_FRONT,  32'h0);
    send_cmd(dq_pkg::CMD_CLEAR,      32'h0);          // clear with elements held
    send_cmd(dq_pkg::CMD_SIZE,       32'h0);

    // Random mix with idling, a full pause, a stretch without gaps, then idling again.
    random_mix(130);
    stop_sending();
    drain();
    idle_enable = 1'b0;
    random_mix(130);
    idle_enable = 1'b1;
    random_mix(130);

    // Wrap the ring once more and clear from a deeper state.
    repeat (20) send_random(dq_pkg::CMD_PUSH_FRONT);
    random_mix(15);
    send_cmd(dq_pkg::CMD_CLEAR, 32'h0);
    send_random(dq_pkg::CMD_PEEK_BACK);

    stop_sending();
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/dq_pkg.sv
src/dq_ram.sv
src/double_ended_queue_top.sv
tb/sv/tb.sv
